// ===== design/tga_pkg.sv =====
package tga_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_PATTERN  = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIM = 2'd1;
  localparam logic [1:0] ERR_DEPTH    = 2'd2;

  localparam int PAT_LEN = 12;

  // header byte positions
  localparam logic [4:0] HPOS_FIRST_PAT  = 5'd1;
  localparam logic [4:0] HPOS_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HPOS_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HPOS_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HPOS_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HPOS_DEPTH      = 5'd16;
  localparam logic [4:0] HPOS_VERDICT    = 5'd17;

  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // uncompressed true-colour header signature, byte 0 unused
  localparam logic [7:0] HDR_PATTERN [0:PAT_LEN-1] = '{
    8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [1:0]  error_code;
    logic        last_pixel;
  } result_t;

endpackage

// ===== design/tga_truecolor_to_rgba_parser_top.sv =====
// a result beat is registered into the output stage, or into the skid stage while the output is stalled
// throughput: one file byte per cycle while in_stall is low, set by the single-pass parser update
// a one-entry skid stage lets bytes flow while a result waits at the output
// reset: synchronous, active low; parser idles until a start-of-file beat,
// output and skid stages empty
module tga_truecolor_to_rgba_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic        out_has_alpha,
  output logic [1:0]  out_error_code,
  output logic        out_last_pixel
);
  import tga_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_data;

  // stall only once the skid stage holds a beat; the output register alone
  // never blocks the input side
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // header check, byte capture and pixel counting
  tga_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register plus skid entry
  tga_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // fields not relevant to a beat's kind are zero from the parser
  assign out_kind         = out_data.kind;
  assign out_red          = out_data.red;
  assign out_green        = out_data.green;
  assign out_blue         = out_data.blue;
  assign out_alpha        = out_data.alpha;
  assign out_image_width  = out_data.image_width;
  assign out_image_height = out_data.image_height;
  assign out_has_alpha    = out_data.has_alpha;
  assign out_error_code   = out_data.error_code;
  assign out_last_pixel   = out_data.last_pixel;

endmodule

// ===== design/tga_parser.sv =====
module tga_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output logic              res_valid,
  output tga_pkg::result_t  res
);
  import tga_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PIXELS, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        pat_ok_r, pat_ok_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        d32_r, d32_nxt;
  logic        dvalid_r, dvalid_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic [1:0]  last_idx;
  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic        last;
  logic        zero_dim;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    pat_ok_nxt = pat_ok_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    d32_nxt    = d32_r;
    dvalid_nxt = dvalid_r;
    bip_nxt    = bip_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    red_nxt    = red_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    res        = '0;
    res_valid  = 1'b0;

    last_idx = d32_r ? 2'd3 : 2'd2;
    col_inc  = {1'b0, col_r} + 17'd1;
    row_inc  = {1'b0, row_r} + 17'd1;
    last     = (col_inc == {1'b0, width_r}) && (row_inc == {1'b0, height_r});
    zero_dim = (width_r == '0) || (height_r == '0);

    if (start_of_file) begin
      phase_nxt  = PH_HEADER;
      pos_nxt    = HPOS_FIRST_PAT;
      pat_ok_nxt = 1'b1;
      width_nxt  = '0;
      height_nxt = '0;
      d32_nxt    = 1'b0;
      dvalid_nxt = 1'b0;
      bip_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          pos_nxt = pos_r + 5'd1;
          if (pos_r >= HPOS_VERDICT) begin
            pos_nxt   = pos_r;
            res_valid = 1'b1;
            if (!pat_ok_r || zero_dim || !dvalid_r) begin
              res.kind = KIND_ERROR;
              if (!pat_ok_r)    res.error_code = ERR_PATTERN;
              else if (zero_dim) res.error_code = ERR_ZERO_DIM;
              else               res.error_code = ERR_DEPTH;
              phase_nxt = PH_DONE;
            end else begin
              res.kind         = KIND_HEADER;
              res.image_width  = width_r;
              res.image_height = height_r;
              res.has_alpha    = d32_r;
              phase_nxt        = PH_PIXELS;
              bip_nxt          = '0;
              col_nxt          = '0;
              row_nxt          = '0;
            end
          end else if (pos_r == HPOS_WIDTH_LO) begin
            width_nxt[7:0] = data_byte;
          end else if (pos_r == HPOS_WIDTH_HI) begin
            width_nxt[15:8] = data_byte;
          end else if (pos_r == HPOS_HEIGHT_LO) begin
            height_nxt[7:0] = data_byte;
          end else if (pos_r == HPOS_HEIGHT_HI) begin
            height_nxt[15:8] = data_byte;
          end else if (pos_r == HPOS_DEPTH) begin
            d32_nxt    = (data_byte == DEPTH_32);
            dvalid_nxt = (data_byte == DEPTH_24) || (data_byte == DEPTH_32);
          end else if (pos_r >= HPOS_FIRST_PAT) begin
            if (data_byte != HDR_PATTERN[pos_r[3:0]]) pat_ok_nxt = 1'b0;
          end
        end
        PH_PIXELS: begin
          if (bip_r == 2'd0) blue_nxt  = data_byte;
          if (bip_r == 2'd1) green_nxt = data_byte;
          if (bip_r == 2'd2) red_nxt   = data_byte;
          if (bip_r < last_idx) begin
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt          = '0;
            res_valid        = 1'b1;
            res.kind         = KIND_PIXEL;
            res.red          = (bip_r == 2'd2) ? data_byte : red_r;
            res.green        = green_r;
            res.blue         = blue_r;
            res.alpha        = d32_r ? data_byte : ALPHA_OPAQUE;
            res.last_pixel   = last;
            if (last) begin
              phase_nxt = PH_DONE;
            end else if (col_inc >= {1'b0, width_r}) begin
              col_nxt = '0;
              row_nxt = row_inc[15:0];
            end else begin
              col_nxt = col_inc[15:0];
            end
          end
        end
        PH_IDLE, PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      pat_ok_r <= pat_ok_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      d32_r    <= d32_nxt;
      dvalid_r <= dvalid_nxt;
      bip_r    <= bip_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      red_r    <= red_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ===== design/tga_outbuf.sv =====
module tga_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tga_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output tga_pkg::result_t  out_data
);
  import tga_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        // skid drains first, a new beat takes its place
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= push;
        skid_data_r  <= push_data;
      end else begin
        out_valid_r <= push;
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= push_data;
    end
  end

endmodule

// ===== design/tga_checker.sv =====
module tga_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha,
  input logic [15:0] out_image_width,
  input logic [15:0] out_image_height,
  input logic        out_has_alpha,
  input logic [1:0]  out_error_code,
  input logic        out_last_pixel
);
  import tga_pkg::*;

  // a held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_red)
      && $stable(out_alpha) && $stable(out_image_width) && $stable(out_last_pixel))
    else $error("stalled result beat changed");

  // an accepted header never reports a zero dimension
  a_hdr_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER |-> out_image_width != '0
      && out_image_height != '0 && out_error_code == '0)
    else $error("header beat with zero dimension");

  // size fields only on header beats
  a_size_only_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HEADER |-> out_image_width == '0
      && out_image_height == '0 && !out_has_alpha)
    else $error("size fields outside header beat");

  // colour and last flag only on pixel beats
  a_colour_only_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PIXEL |-> out_red == '0 && out_green == '0
      && out_blue == '0 && out_alpha == '0 && !out_last_pixel)
    else $error("pixel fields outside pixel beat");

endmodule

bind tga_truecolor_to_rgba_parser_top tga_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_red          (out_red),
  .out_green        (out_green),
  .out_blue         (out_blue),
  .out_alpha        (out_alpha),
  .out_image_width  (out_image_width),
  .out_image_height (out_image_height),
  .out_has_alpha    (out_has_alpha),
  .out_error_code   (out_error_code),
  .out_last_pixel   (out_last_pixel)
);

// ===== tb/tga_truecolor_to_rgba_parser_top_tb.sv =====
module tga_truecolor_to_rgba_parser_top_tb;
  import tga_pkg::*;

  // one byte beat of the file stream as queued for the driver
  typedef struct {
    logic [7:0] data;
    logic       sof;
  } file_beat_t;

  // parser phase as tracked by the decoder model
  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PIXELS, PH_DONE} parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_start_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic        out_has_alpha;
  logic [1:0]  out_error_code;
  logic        out_last_pixel;

  tga_truecolor_to_rgba_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_has_alpha    (out_has_alpha),
    .out_error_code   (out_error_code),
    .out_last_pixel   (out_last_pixel)
  );

  always #5 clk = ~clk;

  // byte stream still to be sent, and decoded results still to arrive
  file_beat_t file_bytes [$];
  result_t    decoded_q [$];

  int  fail_count = 0;
  int  beats_taken = 0;
  int  beats_total = 0;
  bit  in_took = 1'b0;

  // idling mix, moved on as the stream progresses
  int  tx_gap_pct = 22;
  int  rx_stall_pct = 54;

  // decoder model state, reset values
  parse_phase_t ph = PH_IDLE;
  int           hdr_pos = 0;
  bit           pat_ok = 1'b1;
  logic [15:0]  wd = '0;
  logic [15:0]  ht = '0;
  bit           alpha32 = 1'b0;
  bit           depth_ok = 1'b0;
  int           pix_byte = 0;
  logic [7:0]   held_b = '0;
  logic [7:0]   held_g = '0;
  logic [7:0]   held_r = '0;
  int           col = 0;
  int           row = 0;

  // model of the parser: one file byte in, at most one decoded result out
  task automatic decode_byte(input logic [7:0] b, input logic sof);
    result_t r;
    int      last_idx;
    bit      last;
    r = '0;
    if (sof) begin
      // a start beat restarts everything; this byte is the ignored id length
      ph = PH_HEADER;
      hdr_pos = 1;
      pat_ok = 1'b1;
      wd = '0;
      ht = '0;
      alpha32 = 1'b0;
      depth_ok = 1'b0;
      pix_byte = 0;
      held_b = '0;
      held_g = '0;
      held_r = '0;
      col = 0;
      row = 0;
    end else if (ph == PH_HEADER) begin
      if (hdr_pos >= 17) begin
        // verdict on the skipped last header byte; the pattern wins, then dimensions
        if (!pat_ok || wd == 0 || ht == 0 || !depth_ok) begin
          r.kind = KIND_ERROR;
          r.error_code = !pat_ok ? ERR_PATTERN : ((wd == 0 || ht == 0) ? ERR_ZERO_DIM : ERR_DEPTH);
          ph = PH_DONE;
        end else begin
          r.kind = KIND_HEADER;
          r.image_width = wd;
          r.image_height = ht;
          r.has_alpha = alpha32;
          ph = PH_PIXELS;
          pix_byte = 0;
          col = 0;
          row = 0;
        end
        decoded_q.push_back(r);
      end else begin
        case (hdr_pos)
          12: wd[7:0] = b;
          13: wd[15:8] = b;
          14: ht[7:0] = b;
          15: ht[15:8] = b;
          16: begin
            alpha32 = (b == DEPTH_32);
            depth_ok = (b == DEPTH_24) || (b == DEPTH_32);
          end
          default: if (b != HDR_PATTERN[hdr_pos]) pat_ok = 1'b0;
        endcase
        hdr_pos++;
      end
    end else if (ph == PH_PIXELS) begin
      // bytes arrive as b, g, r and, at 32 bits, a
      last_idx = alpha32 ? 3 : 2;
      case (pix_byte)
        0: held_b = b;
        1: held_g = b;
        2: held_r = b;
        default: ;
      endcase
      if (pix_byte < last_idx) begin
        pix_byte++;
      end else begin
        pix_byte = 0;
        r.kind = KIND_PIXEL;
        r.red = held_r;
        r.green = held_g;
        r.blue = held_b;
        r.alpha = alpha32 ? b : ALPHA_OPAQUE;
        last = (col + 1 == int'(wd)) && (row + 1 == int'(ht));
        r.last_pixel = last;
        if (last) begin
          ph = PH_DONE;
        end else if (col + 1 >= int'(wd)) begin
          col = 0;
          row = (row + 1) & 16'hFFFF;
        end else begin
          col++;
        end
        decoded_q.push_back(r);
      end
    end
    // idle and done: bytes are dropped
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // stimulus helpers
  task automatic add_byte(input logic [7:0] b, input logic sof);
    file_beat_t fb;
    fb.data = b;
    fb.sof = sof;
    file_bytes.push_back(fb);
  endtask

  // full 18-byte header; bad_pos in 1..11 replaces that signature byte with bad_val
  task automatic add_header(input logic [7:0] id_len, input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] depth, input int bad_pos, input logic [7:0] bad_val);
    add_byte(id_len, 1'b1);
    for (int p = 1; p < PAT_LEN; p++)
      add_byte((p == bad_pos) ? bad_val : HDR_PATTERN[p], 1'b0);
    add_byte(w[7:0], 1'b0);
    add_byte(w[15:8], 1'b0);
    add_byte(h[7:0], 1'b0);
    add_byte(h[15:8], 1'b0);
    add_byte(depth, 1'b0);
    add_byte(8'($urandom), 1'b0);
  endtask

  // fill below zero means random content
  task automatic add_pixel_bytes(input int n, input int fill);
    for (int i = 0; i < n; i++)
      add_byte((fill < 0) ? 8'($urandom) : 8'(fill), 1'b0);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom), 1'b0);
  endtask

  // driver: a new beat only once the current one has gone or none is up
  always @(negedge clk) begin
    file_beat_t fb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (file_bytes.size() > 0 && $urandom_range(99) >= tx_gap_pct) begin
        fb = file_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= fb.data;
        in_start_of_file <= fb.sof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_stall_pct);
  end

  // monitor: feeds accepted byte beats to the model, checks each result beat
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte, in_start_of_file);
        beats_taken++;
        // receiver-heavy idling, then sender-heavy, then free flow
        if (beats_taken >= (2 * beats_total) / 3) begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end else if (beats_taken >= beats_total / 3) begin
          tx_gap_pct = 54;
          rx_stall_pct = 22;
        end
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result beat with none due, expected none actual kind %0h",
                   $time, out_kind);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("red", 16'(want.red), 16'(out_red));
          check_field("green", 16'(want.green), 16'(out_green));
          check_field("blue", 16'(want.blue), 16'(out_blue));
          check_field("alpha", 16'(want.alpha), 16'(out_alpha));
          check_field("image_width", want.image_width, out_image_width);
          check_field("image_height", want.image_height, out_image_height);
          check_field("has_alpha", 16'(want.has_alpha), 16'(out_has_alpha));
          check_field("error_code", 16'(want.error_code), 16'(out_error_code));
          check_field("last_pixel", 16'(want.last_pixel), 16'(out_last_pixel));
        end
      end
    end
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int         kind_sel;
    int         w;
    int         h;
    int         bpp;
    int         n;
    int         pos;
    int         k;
    logic [7:0] d;

    // directed files
    // stray bytes before any start of file
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    // 1x1 at 24 bits, all-ones pixel, largest id length, then trailing bytes ignored
    add_header(8'hFF, 16'd1, 16'd1, DEPTH_24, 0, 8'h00);
    add_pixel_bytes(3, 255);
    add_noise(2);
    // 1x1 at 32 bits, all-zero pixel
    add_header(8'h00, 16'd1, 16'd1, DEPTH_32, 0, 8'h00);
    add_pixel_bytes(4, 0);
    // 2x2 at 32 bits for the row wrap
    add_header(8'h00, 16'd2, 16'd2, DEPTH_32, 0, 8'h00);
    add_pixel_bytes(16, -1);
    // run-length image type, a signature mismatch; later bytes ignored
    add_header(8'h00, 16'd1, 16'd1, DEPTH_24, 2, 8'h0A);
    add_noise(3);
    // zero width, then zero height
    add_header(8'h00, 16'd0, 16'd3, DEPTH_24, 0, 8'h00);
    add_header(8'h00, 16'd3, 16'd0, DEPTH_32, 0, 8'h00);
    // 16-bit depth
    add_header(8'h00, 16'd2, 16'd2, 8'd16, 0, 8'h00);
    // every fault at once: pattern wins; zero dimension beats bad depth
    add_header(8'h00, 16'd0, 16'd0, 8'd8, 11, 8'hFF);
    add_header(8'h00, 16'd0, 16'd5, 8'd33, 0, 8'h00);
    // restart in mid-header
    add_byte(8'h12, 1'b1);
    add_noise(7);
    // largest dimensions, a few pixels, then restart in mid-pixel
    add_header(8'h00, 16'hFFFF, 16'hFFFF, DEPTH_32, 0, 8'h00);
    add_pixel_bytes(10, -1);
    // 3x1 at 24 bits
    add_header(8'h00, 16'd3, 16'd1, DEPTH_24, 0, 8'h00);
    add_pixel_bytes(9, -1);

    // random files, mostly well formed with random content
    k = 0;
    while (file_bytes.size() < 1700) begin
      kind_sel = $urandom_range(99);
      bpp = $urandom_range(1) ? 4 : 3;
      d = (bpp == 4) ? DEPTH_32 : DEPTH_24;
      if (k == 5) begin
        // width with only the high byte set, a single row
        add_header(8'($urandom), 16'h0100, 16'd1, DEPTH_24, 0, 8'h00);
        add_pixel_bytes(256 * 3, -1);
      end else if (kind_sel < 68) begin
        w = $urandom_range(1, 5);
        h = $urandom_range(1, 4);
        add_header(8'($urandom), 16'(w), 16'(h), d, 0, 8'h00);
        add_pixel_bytes(w * h * bpp, -1);
        add_noise($urandom_range(0, 3));
      end else if (kind_sel < 78) begin
        pos = $urandom_range(1, PAT_LEN - 1);
        add_header(8'($urandom), 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                   8'($urandom), pos, HDR_PATTERN[pos] ^ 8'($urandom_range(1, 255)));
        add_noise($urandom_range(0, 2));
      end else if (kind_sel < 84) begin
        w = $urandom_range(1) ? 0 : $urandom_range(0, 65535);
        h = (w != 0) ? 0 : $urandom_range(0, 65535);
        add_header(8'($urandom), 16'(w), 16'(h), $urandom_range(1) ? d : 8'($urandom), 0, 8'h00);
      end else if (kind_sel < 90) begin
        d = 8'($urandom);
        if (d == DEPTH_24 || d == DEPTH_32)
          d = 8'd15;
        add_header(8'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   d, 0, 8'h00);
      end else if (kind_sel < 96) begin
        // short file with large dimensions, cut off by the next start
        add_header(8'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   d, 0, 8'h00);
        add_pixel_bytes($urandom_range(0, 12), -1);
      end else begin
        // noise with the odd start beat, possibly cut off mid-header
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          add_byte(8'($urandom), $urandom_range(9) == 0);
      end
      k++;
    end
    beats_total = file_bytes.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all bytes sent, then every result in, then a wait for strays
    while (file_bytes.size() != 0 || in_valid)
      @(posedge clk);
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tga_pkg.sv
design/tga_parser.sv
design/tga_outbuf.sv
design/tga_truecolor_to_rgba_parser_top.sv
design/tga_checker.sv
tb/tga_truecolor_to_rgba_parser_top_tb.sv
